// ===== hw/rtl/servo_linear_move_interpolator_unit_macros.svh =====
// Assertion macros shared by the servo move interpolator RTL.
`ifndef SERVO_LINEAR_MOVE_INTERPOLATOR_UNIT_MACROS_SVH
`define SERVO_LINEAR_MOVE_INTERPOLATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SLMI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slmi: assertion failed");
`define SLMI_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("slmi: forbidden condition seen");
`else
`define SLMI_ASSERT(lbl, clk, rst_n, prop)
`define SLMI_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/slmi_pkg.sv =====
// Types, constants and microcode ROM of the servo move interpolator.
`timescale 1ns / 1ps
`default_nettype none
package slmi_pkg;

  localparam int TICK_COUNT_BITS = 8;
  localparam int AXES     = 4;
  localparam int AX_W     = 2;
  localparam int POS_W    = 7;
  localparam int PW       = 25;
  localparam int CNT_W    = 8;
  localparam int ACC_W    = 25;
  localparam int SPAN_QBITS = 19;  // span / 100 for a 25-bit span
  localparam int POS_QBITS  = 7;   // quotients that stay at or below 100
  localparam int QUO_W    = POS_QBITS;
  localparam int UPC_W    = 4;
  localparam int REP_W    = 5;

  localparam logic [POS_W-1:0] POS_FULL = POS_W'(100);
  localparam logic [POS_W-1:0] POS_MID  = POS_W'(50);
  localparam logic [15:0] TICK_MAX = 16'((1 << TICK_COUNT_BITS) - 1);
  localparam logic [TICK_COUNT_BITS-1:0] RESET_TICKS = TICK_COUNT_BITS'(10);

  // Divide by 100 as multiply and shift.
  // ceil(2^31 / 100): exact for every 25-bit span.
  localparam int             RECIP_SH   = 31;
  localparam logic [PW-1:0]  RECIP_SPAN = PW'(21474837);
  // ceil(2^20 / 100): exact for products below 43690.
  localparam int                 FRAC_SH    = 20;
  localparam logic [2*POS_W-1:0] RECIP_FRAC = (2*POS_W)'(10486);

  localparam logic [PW-1:0]    RESET_PULSE_MIN = PW'(1000000);
  localparam logic [PW-1:0]    RESET_PULSE_MAX = PW'(2000000);
  localparam logic [CNT_W-1:0] RESET_DEF_COUNT = CNT_W'(10);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [1:0] {
    CFG_PULSE_MIN = 2'd0,
    CFG_PULSE_MAX = 2'd1,
    CFG_DEF_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             command;
    logic [POS_W-1:0] goal_eye_a_x;
    logic [POS_W-1:0] goal_eye_a_y;
    logic [POS_W-1:0] goal_eye_b_x;
    logic [POS_W-1:0] goal_eye_b_y;
    logic [CNT_W-1:0] move_ticks;
  } in_item_t;

  typedef struct packed {
    logic [PW-1:0] width_a_x;
    logic [PW-1:0] width_a_y;
    logic [PW-1:0] width_b_x;
    logic [PW-1:0] width_b_y;
    logic          final_step;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_SPAN   = 3'd0,
    OP_DIV    = 3'd1,
    OP_SAVE   = 3'd2,
    OP_AXLOAD = 3'd3,
    OP_POS    = 3'd4,
    OP_PULSE  = 3'd5,
    OP_EMIT   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE = 2'd0,
    COND_REP  = 2'd1,
    COND_AX   = 2'd2,
    COND_END  = 2'd3
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic [REP_W-1:0] rep;
  } ucw_t;

  typedef struct packed {
    logic            busy;
    op_t             op;
    logic [AX_W-1:0] ax;
  } ctrl_t;

  localparam logic [UPC_W-1:0] UPC_SPAN     = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_SAVE     = UPC_W'(1);
  localparam logic [UPC_W-1:0] UPC_AXLOAD   = UPC_W'(2);
  localparam logic [UPC_W-1:0] UPC_POS_DIV  = UPC_W'(3);
  localparam logic [UPC_W-1:0] UPC_POS      = UPC_W'(4);
  localparam logic [UPC_W-1:0] UPC_PULSE    = UPC_W'(5);
  localparam logic [UPC_W-1:0] UPC_EMIT     = UPC_W'(6);

  localparam logic [REP_W-1:0] REP_POS  = REP_W'(POS_QBITS - 1);

  // Tick program: span quotient and remainder, then per axis: interpolate, scale; then emit.
  function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
    ucw_t w;
    w = '{op: OP_EMIT, cond: COND_END, target: UPC_SPAN, rep: '0};
    unique case (upc)
      UPC_SPAN:     w = '{op: OP_SPAN,   cond: COND_NONE, target: UPC_SPAN,     rep: '0};
      UPC_SAVE:     w = '{op: OP_SAVE,   cond: COND_NONE, target: UPC_SAVE,     rep: '0};
      UPC_AXLOAD:   w = '{op: OP_AXLOAD, cond: COND_NONE, target: UPC_AXLOAD,   rep: REP_POS};
      UPC_POS_DIV:  w = '{op: OP_DIV,    cond: COND_REP,  target: UPC_POS_DIV,  rep: '0};
      UPC_POS:      w = '{op: OP_POS,    cond: COND_NONE, target: UPC_POS,      rep: '0};
      UPC_PULSE:    w = '{op: OP_PULSE,  cond: COND_AX,   target: UPC_AXLOAD,   rep: '0};
      UPC_EMIT:     w = '{op: OP_EMIT,   cond: COND_END,  target: UPC_SPAN,     rep: '0};
      default:      w = '{op: OP_EMIT,   cond: COND_END,  target: UPC_SPAN,     rep: '0};
    endcase
    return w;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v);
    return (v > POS_FULL) ? POS_FULL : v;
  endfunction

  function automatic logic [TICK_COUNT_BITS-1:0] clamp_ticks(input logic [CNT_W-1:0] v);
    logic [15:0] v16;
    v16 = 16'(v);
    return (v16 > TICK_MAX) ? TICK_MAX[TICK_COUNT_BITS-1:0] : v16[TICK_COUNT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/slmi_useq.sv =====
// Microcode sequencer: step counter, repeat counter, axis counter and ROM.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_linear_move_interpolator_unit_macros.svh"
module slmi_useq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire logic           emit_ok,
  output slmi_pkg::ctrl_t     ctrl
);
  import slmi_pkg::*;

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic [REP_W-1:0] rep_r, rep_nxt;
  logic [AX_W-1:0]  ax_r, ax_nxt;
  ucw_t             word;

  assign word = ucode(upc_r);

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    rep_nxt  = rep_r;
    ax_nxt   = ax_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        upc_nxt  = UPC_SPAN;
        ax_nxt   = '0;
      end
    end else begin
      unique case (word.cond)
        COND_NONE: begin
          upc_nxt = upc_r + UPC_W'(1);
          rep_nxt = word.rep;
        end
        COND_REP: begin
          if (rep_r != '0) begin
            rep_nxt = rep_r - REP_W'(1);
            upc_nxt = word.target;
          end else begin
            upc_nxt = upc_r + UPC_W'(1);
          end
        end
        COND_AX: begin
          if (ax_r != AX_W'(AXES - 1)) begin
            ax_nxt  = ax_r + AX_W'(1);
            upc_nxt = word.target;
          end else begin
            upc_nxt = upc_r + UPC_W'(1);
          end
        end
        COND_END: begin
          // hold here while the output register holds a previous result that is not yet taken
          if (emit_ok) begin
            busy_nxt = 1'b0;
            upc_nxt  = UPC_SPAN;
          end
        end
        default: upc_nxt = UPC_SPAN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UPC_SPAN;
      rep_r  <= '0;
      ax_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      rep_r  <= rep_nxt;
      ax_r   <= ax_nxt;
    end
  end

  assign ctrl.busy = busy_r;
  assign ctrl.op   = word.op;
  assign ctrl.ax   = ax_r;

  `SLMI_NEVER(a_go_while_busy, clk, rst_n, go && busy_r)
  `SLMI_ASSERT(a_done_only_at_end, clk, rst_n, $fell(busy_r) |-> $past(word.cond == COND_END))

endmodule
`default_nettype wire

// ===== hw/rtl/slmi_datapath.sv =====
// Shared datapath: restoring divide step, interpolation and pulse scaling.
`timescale 1ns / 1ps
`default_nettype none
module slmi_datapath (
  input  wire logic                                             clk,
  input  wire slmi_pkg::ctrl_t                                  ctrl,
  input  wire logic [slmi_pkg::PW-1:0]                          pulse_min,
  input  wire logic [slmi_pkg::PW-1:0]                          pulse_max,
  input  wire logic [slmi_pkg::AXES-1:0][slmi_pkg::POS_W-1:0]   start_pts,
  input  wire logic [slmi_pkg::AXES-1:0][slmi_pkg::POS_W-1:0]   end_pts,
  input  wire logic [slmi_pkg::TICK_COUNT_BITS-1:0]             done,
  input  wire logic [slmi_pkg::TICK_COUNT_BITS-1:0]             total,
  output logic      [slmi_pkg::AXES-1:0][slmi_pkg::PW-1:0]      widths
);
  import slmi_pkg::*;

  localparam int PROD_W  = POS_W + TICK_COUNT_BITS;
  localparam int FPROD_W = 2*POS_W;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [SPAN_QBITS-1:0] qs_r;    // span / 100
  logic [POS_W-1:0] rs_r;    // span % 100
  logic [POS_W-1:0] pos_r;
  logic [FPROD_W-1:0] fprod_r;
  logic             neg_r;
  logic [AXES-1:0][PW-1:0] w_r;

  logic [PW-1:0]           span;
  logic [POS_W-1:0]        s_pt, e_pt, mag, pos;
  logic                    neg;
  logic [PROD_W-1:0]       prod;
  logic [2*PW-1:0]         qspan;
  logic [PW-1:0]           rspan;
  logic [FPROD_W-1:0]      fprod;
  logic [2*FPROD_W-1:0]    fscaled;
  logic [SPAN_QBITS+POS_W-1:0] qprod;
  logic [PW-1:0]           pulse;
  logic                    ge;

  assign span  = (pulse_max > pulse_min) ? (pulse_max - pulse_min) : '0;
  assign qspan = (2*PW)'(span) * (2*PW)'(RECIP_SPAN);
  // true remainder is below 100, so the low bits of the difference carry it
  assign rspan = span - PW'(qs_r) * PW'(POS_FULL);
  assign s_pt  = start_pts[ctrl.ax];
  assign e_pt  = end_pts[ctrl.ax];
  assign neg   = e_pt < s_pt;
  assign mag   = neg ? (s_pt - e_pt) : (e_pt - s_pt);
  assign prod  = PROD_W'(mag) * PROD_W'(done);
  // magnitude was divided, so applying the sign truncates toward zero
  assign pos   = neg_r ? (s_pt - quo_r) : (s_pt + quo_r);
  assign fprod = FPROD_W'(rs_r) * FPROD_W'(pos);
  assign fscaled = (2*FPROD_W)'(fprod_r) * (2*FPROD_W)'(RECIP_FRAC);
  assign qprod = (SPAN_QBITS+POS_W)'(qs_r) * (SPAN_QBITS+POS_W)'(pos_r);
  // span * pos / 100 = (span / 100) * pos + (span % 100) * pos / 100
  assign pulse = pulse_min + qprod[PW-1:0] + PW'(fscaled[FRAC_SH +: POS_W]);
  assign ge    = acc_r >= dsh_r;

  always_comb begin
    acc_nxt = acc_r;
    dsh_nxt = dsh_r;
    quo_nxt = quo_r;
    if (ctrl.busy) begin
      case (ctrl.op)
        OP_DIV: begin
          if (ge) acc_nxt = acc_r - dsh_r;
          quo_nxt = {quo_r[QUO_W-2:0], ge};
          dsh_nxt = dsh_r >> 1;
        end
        OP_AXLOAD: begin
          acc_nxt = ACC_W'(prod);
          dsh_nxt = ACC_W'(total) << (POS_QBITS - 1);
          quo_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    if (ctrl.busy && ctrl.op == OP_SPAN) qs_r <= qspan[RECIP_SH +: SPAN_QBITS];
    if (ctrl.busy && ctrl.op == OP_SAVE) rs_r <= rspan[POS_W-1:0];
    if (ctrl.busy && ctrl.op == OP_AXLOAD) neg_r <= neg;
    if (ctrl.busy && ctrl.op == OP_POS) begin
      pos_r   <= pos;
      fprod_r <= fprod;
    end
    if (ctrl.busy && ctrl.op == OP_PULSE) w_r[ctrl.ax] <= pulse;
  end

  assign widths = w_r;

endmodule
`default_nettype wire

// ===== hw/rtl/servo_linear_move_interpolator_unit.sv =====
// Top level of the four-axis servo move interpolator.
// Move beat: taken while idle, updates targets and gives no result.
// Tick beat of a running move: result registered at the end of the program below;
//   in_ready stays low until then, so a new tick is taken only after the last is emitted.
// Steps: span split, then per axis load, divide by total, interpolate, scale; then emit; a full output holds emit.
// Synchronous active-low reset: axes at 50, block idle, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_linear_move_interpolator_unit_macros.svh"
module servo_linear_move_interpolator_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire slmi_pkg::in_item_t     in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output slmi_pkg::out_item_t         out_data,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [slmi_pkg::PW-1:0] cfg_wdata
);
  import slmi_pkg::*;

  logic [PW-1:0]    pmin_r, pmin_nxt;
  logic [PW-1:0]    pmax_r, pmax_nxt;
  logic [CNT_W-1:0] defcnt_r, defcnt_nxt;

  logic [AXES-1:0][POS_W-1:0] start_r, start_nxt;
  logic [AXES-1:0][POS_W-1:0] end_r, end_nxt;
  logic [TICK_COUNT_BITS-1:0] done_r, done_nxt;
  logic [TICK_COUNT_BITS-1:0] total_r, total_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  ctrl_t                  ctrl;
  logic [AXES-1:0][PW-1:0] widths;
  logic                   in_fire, tick_go, emit_ok, emit;
  logic [CNT_W-1:0]       cnt;

  assign in_ready = !ctrl.busy;
  assign in_fire  = in_valid && in_ready;
  assign tick_go  = in_fire && (in_data.command == CMD_TICK) && (done_r < total_r);
  assign emit_ok  = !out_valid_r || out_ready;
  assign emit     = ctrl.busy && (ctrl.op == OP_EMIT) && emit_ok;
  assign cnt      = (in_data.move_ticks == '0) ? defcnt_r : in_data.move_ticks;

  always_comb begin
    pmin_nxt   = pmin_r;
    pmax_nxt   = pmax_r;
    defcnt_nxt = defcnt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_MIN: pmin_nxt   = cfg_wdata;
        CFG_PULSE_MAX: pmax_nxt   = cfg_wdata;
        CFG_DEF_COUNT: defcnt_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    done_nxt  = done_r;
    total_nxt = total_r;
    if (in_fire) begin
      if (in_data.command == CMD_MOVE) begin
        start_nxt  = end_r;
        end_nxt[0] = clamp_pos(in_data.goal_eye_a_x);
        end_nxt[1] = clamp_pos(in_data.goal_eye_a_y);
        end_nxt[2] = clamp_pos(in_data.goal_eye_b_x);
        end_nxt[3] = clamp_pos(in_data.goal_eye_b_y);
        total_nxt  = clamp_ticks(cnt);
        done_nxt   = '0;
      end else if (tick_go) begin
        done_nxt = done_r + TICK_COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.width_a_x  = widths[0];
      out_data_nxt.width_a_y  = widths[1];
      out_data_nxt.width_b_x  = widths[2];
      out_data_nxt.width_b_y  = widths[3];
      out_data_nxt.final_step = (done_r == total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmin_r      <= RESET_PULSE_MIN;
      pmax_r      <= RESET_PULSE_MAX;
      defcnt_r    <= RESET_DEF_COUNT;
      start_r     <= {AXES{POS_MID}};
      end_r       <= {AXES{POS_MID}};
      done_r      <= RESET_TICKS;
      total_r     <= RESET_TICKS;
      out_valid_r <= 1'b0;
    end else begin
      pmin_r      <= pmin_nxt;
      pmax_r      <= pmax_nxt;
      defcnt_r    <= defcnt_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      done_r      <= done_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  slmi_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (tick_go),
    .emit_ok (emit_ok),
    .ctrl    (ctrl)
  );

  slmi_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .pulse_min (pmin_r),
    .pulse_max (pmax_r),
    .start_pts (start_r),
    .end_pts   (end_r),
    .done      (done_r),
    .total     (total_r),
    .widths    (widths)
  );

  `SLMI_ASSERT(a_tick_starts_program, clk, rst_n, tick_go |=> ctrl.busy)
  `SLMI_ASSERT(a_emit_loads_output, clk, rst_n, emit |=> out_valid_r)
  `SLMI_ASSERT(a_done_within_total, clk, rst_n, done_r <= total_r)

endmodule
`default_nettype wire
